// ===== rtl/core/hcbd_pkg.sv =====
// Shared types, constants and helpers for the HTTP chunked body decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Depth of the queue between the front and the back, and its pointer width.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // One classified input byte, as handed from the front to the back.
   typedef struct packed {
      logic [7:0] data;       // the input byte
      logic       cr_emit;    // a held CR is released as body data first
      logic       byte_emit;  // the input byte itself is body data
      logic       done;       // final chunk seen, after this byte
      logic       err;        // sticky framing error, after this byte
   } rec_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h61 + 8'd10);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== rtl/core/http_chunked_body_decoder.sv =====
// Channel  Ports             Payload (lowest bit first)
// req      req_t*            tdata: in_byte[7:0]
// rsp      rsp_t*            tdata: data_byte[7:0], body_done, framing_error, zeros;
//                            tuser: is_data; tlast: last
//
// One byte is accepted per cycle while the queue has room; its results pass through
// the queue and then the registered result channel. A byte that releases a held CR
// with a data byte gives two beats, sent in turn; a four-entry queue lets the front keep
// taking bytes. Reset is synchronous; all framing state returns to size mode.
// A stalled rsp side fills the queue, after which req_tready drops.
// Top level of the HTTP chunked body decoder; depends on hcbd_pkg, hcbd_front,
// hcbd_fifo and hcbd_back.
`timescale 1ns / 1ps

module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int MAX_SIZE_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [8] body_done, [9] framing_error
   output logic [0:0]  rsp_tuser,   // [0] is_data
   output logic        rsp_tlast
);

   logic       push;
   logic       not_full;
   logic       not_empty;
   logic       pop;
   rec_type    rec;
   rec_type    head;
   logic [7:0] data_byte;
   logic       is_data;
   logic       body_done;
   logic       framing_error;

   assign req_tready = not_full;
   assign push       = req_tvalid && not_full;

   hcbd_front #(
      .MAX_SIZE_DIGITS(MAX_SIZE_DIGITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .in_byte (req_tdata),
      .rec     (rec)
   );

   hcbd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (rec),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   hcbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .not_empty     (not_empty),
      .head          (head),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .data_byte     (data_byte),
      .is_data       (is_data),
      .body_done     (body_done),
      .framing_error (framing_error),
      .last          (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, framing_error, body_done, data_byte};
   assign rsp_tuser = is_data;

endmodule

// ===== rtl/core/hcbd_front.sv =====
// Front end of the chunked body decoder: parses each byte and updates the framing state.
// Depends on hcbd_pkg; feeds one rec_type per accepted byte into the queue.
`timescale 1ns / 1ps

module hcbd_front
   import hcbd_pkg::*;
#(
   parameter int MAX_SIZE_DIGITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] in_byte,
   output rec_type    rec
);

   localparam int CntW = $clog2(MAX_SIZE_DIGITS + 1);

   logic            in_chunk_data_ff, in_chunk_data_in;
   logic            cr_pending_ff,    cr_pending_in;
   logic [31:0]     size_accum_ff,    size_accum_in;
   logic            size_stopped_ff,  size_stopped_in;
   logic [CntW-1:0] digit_cnt_ff,     digit_cnt_in;
   logic [31:0]     expected_len_ff,  expected_len_in;
   logic [31:0]     received_len_ff,  received_len_in;
   logic            finished_ff,      finished_in;
   logic            error_ff,         error_in;

   logic            cr_emit;
   logic            byte_emit;
   logic            handled;
   logic            size_in_use;
   logic [7:0]      size_byte;
   hex_type         hx;
   logic [32:0]     rx_sum;

   always_comb begin
      in_chunk_data_in = in_chunk_data_ff;
      cr_pending_in    = cr_pending_ff;
      size_accum_in    = size_accum_ff;
      size_stopped_in  = size_stopped_ff;
      digit_cnt_in     = digit_cnt_ff;
      expected_len_in  = expected_len_ff;
      finished_in      = finished_ff;
      error_in         = error_ff;
      cr_emit          = 1'b0;
      byte_emit        = 1'b0;
      handled          = 1'b0;
      size_in_use      = 1'b0;
      size_byte        = in_byte;
      received_len_in  = received_len_ff;

      if (!finished_ff) begin
         if (cr_pending_ff) begin
            cr_pending_in = 1'b0;
            if (in_byte == CH_LF) begin
               handled = 1'b1;
               if (!in_chunk_data_ff) begin
                  expected_len_in = size_accum_ff;
                  size_accum_in   = '0;
                  size_stopped_in = 1'b0;
                  digit_cnt_in    = '0;
                  if (size_accum_ff == 32'd0) begin
                     finished_in = 1'b1;
                  end else begin
                     in_chunk_data_in = 1'b1;
                  end
               end else begin
                  if (received_len_ff != expected_len_ff) begin
                     error_in = 1'b1;
                  end
                  in_chunk_data_in = 1'b0;
               end
            end else if (in_chunk_data_ff) begin
               cr_emit = 1'b1;
            end else begin
               // A lone CR on the size line is a non-hex byte and ends the size.
               size_stopped_in = 1'b1;
            end
         end
         if (!handled) begin
            if (in_byte == CH_CR) begin
               cr_pending_in = 1'b1;
            end else if (in_chunk_data_ff) begin
               byte_emit = 1'b1;
            end else begin
               size_in_use = 1'b1;
            end
         end
      end

      hx = hex_decode(size_byte);
      if (size_in_use && !size_stopped_in) begin
         if (!hx.valid) begin
            size_stopped_in = 1'b1;
         end else if (digit_cnt_ff >= CntW'(MAX_SIZE_DIGITS)) begin
            error_in        = 1'b1;
            size_stopped_in = 1'b1;
         end else begin
            size_accum_in = {size_accum_ff[27:0], hx.value};
            digit_cnt_in  = digit_cnt_ff + 1'b1;
         end
      end

      // Count up to two data bytes per input byte, saturating at all ones; a CR LF clears the count.
      rx_sum = {1'b0, received_len_ff} + 33'(cr_emit) + 33'(byte_emit);
      if (handled) begin
         received_len_in = '0;
      end else if (rx_sum[32]) begin
         received_len_in = '1;
      end else begin
         received_len_in = rx_sum[31:0];
      end
   end

   assign rec.data      = in_byte;
   assign rec.cr_emit   = cr_emit;
   assign rec.byte_emit = byte_emit;
   assign rec.done      = finished_in;
   assign rec.err       = error_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_chunk_data_ff <= 1'b0;
         cr_pending_ff    <= 1'b0;
         size_accum_ff    <= '0;
         size_stopped_ff  <= 1'b0;
         digit_cnt_ff     <= '0;
         expected_len_ff  <= '0;
         received_len_ff  <= '0;
         finished_ff      <= 1'b0;
         error_ff         <= 1'b0;
      end else if (push) begin
         in_chunk_data_ff <= in_chunk_data_in;
         cr_pending_ff    <= cr_pending_in;
         size_accum_ff    <= size_accum_in;
         size_stopped_ff  <= size_stopped_in;
         digit_cnt_ff     <= digit_cnt_in;
         expected_len_ff  <= expected_len_in;
         received_len_ff  <= received_len_in;
         finished_ff      <= finished_in;
         error_ff         <= error_in;
      end
   end

endmodule

// ===== rtl/core/hcbd_fifo.sv =====
// Short queue of classified bytes between the decoder front and back.
// Depends on hcbd_pkg for rec_type and the queue depth.
`timescale 1ns / 1ps

module hcbd_fifo
   import hcbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output rec_type head
);

   rec_type            mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   count_ff,  count_in;

   assign not_full  = (count_ff != (FIFO_AW + 1)'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/hcbd_back.sv =====
// Back end of the chunked body decoder: turns queued records into result beats.
// Depends on hcbd_pkg; holds the registered result channel.
`timescale 1ns / 1ps

module hcbd_back
   import hcbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       not_empty,
   input  rec_type    head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] data_byte,
   output logic       is_data,
   output logic       body_done,
   output logic       framing_error,
   output logic       last
);

   logic       out_valid_ff, out_valid_in;
   logic       pend_ff,      pend_in;
   logic [7:0] data_ff,      data_in;
   logic       is_data_ff,   is_data_in;
   logic       done_ff,      done_in;
   logic       err_ff,       err_in;
   logic       last_ff,      last_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       can_load;

   always_comb begin
      can_load     = !out_valid_ff || out_ready;
      pop          = 1'b0;
      out_valid_in = out_valid_ff;
      pend_in      = pend_ff;
      data_in      = data_ff;
      is_data_in   = is_data_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      pend_byte_in = pend_byte_ff;
      if (can_load) begin
         if (pend_ff) begin
            // Second beat of a byte that released a held CR; status is unchanged.
            out_valid_in = 1'b1;
            pend_in      = 1'b0;
            data_in      = pend_byte_ff;
            is_data_in   = 1'b1;
            last_in      = 1'b1;
         end else if (not_empty) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            done_in      = head.done;
            err_in       = head.err;
            pend_byte_in = head.data;
            pend_in      = head.cr_emit && head.byte_emit;
            last_in      = !(head.cr_emit && head.byte_emit);
            if (head.cr_emit) begin
               data_in    = CH_CR;
               is_data_in = 1'b1;
            end else if (head.byte_emit) begin
               data_in    = head.data;
               is_data_in = 1'b1;
            end else begin
               data_in    = 8'd0;
               is_data_in = 1'b0;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      data_ff      <= data_in;
      is_data_ff   <= is_data_in;
      done_ff      <= done_in;
      err_ff       <= err_in;
      last_ff      <= last_in;
      pend_byte_ff <= pend_byte_in;
   end

   assign out_valid     = out_valid_ff;
   assign data_byte     = data_ff;
   assign is_data       = is_data_ff;
   assign body_done     = done_ff;
   assign framing_error = err_ff;
   assign last          = last_ff;

   a_pend_has_beat: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> out_valid_ff)
      else $error("second beat pending without a first beat on the output");

   a_not_last_pend: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff) |-> pend_ff)
      else $error("non-final beat shown without a second beat pending");

   a_second_beat: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff && out_ready) |=> (out_valid_ff && last_ff && is_data_ff))
      else $error("first of two beats was not followed by a final data beat");

endmodule

// ===== sim/http_chunked_body_decoder_tb.sv =====
// Self-checking testbench for the HTTP chunked body decoder: directed framing cases,
// random chunked bodies and noise, checked beat by beat against a decoding model.
// Depends on hcbd_pkg and http_chunked_body_decoder.
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
   import hcbd_pkg::*;

   localparam int MAX_DIGITS = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       is_data;
      logic       done;
      logic       err;
      logic       last;
   } beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] data_byte, [8] body_done, [9] framing_error
   logic [0:0]  rsp_tuser;            // [0] is_data
   logic        rsp_tlast;

   // Decoder state as the model sees it after every accepted byte.
   bit          in_data    = 1'b0;
   bit          cr_held    = 1'b0;
   bit          size_halt  = 1'b0;
   bit          body_end   = 1'b0;
   bit          sticky_err = 1'b0;
   logic [31:0] size_acc   = '0;
   logic [31:0] want_len   = '0;
   logic [31:0] got_len    = '0;
   int          digit_cnt  = 0;

   beat_type due_beats[$];
   beat_type got_beat;
   beat_type want_beat;
   int       mismatches = 0;
   int       sent_count = 0;
   int       rsp_stall;
   bit       burst_mode = 1'b0;
   bit       hold_body  = 1'b0;

   http_chunked_body_decoder #(
      .MAX_SIZE_DIGITS(MAX_DIGITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function void take_size_char(input logic [7:0] c);
      int v;
      v = nibble_of(c);
      if (size_halt) return;
      if (v < 0) begin
         size_halt = 1'b1;
      end else if (digit_cnt >= MAX_DIGITS) begin
         // One digit too many: flag it and keep the size built so far.
         sticky_err = 1'b1;
         size_halt  = 1'b1;
      end else begin
         size_acc = {size_acc[27:0], 4'(v)};
         digit_cnt++;
      end
   endfunction

   // Advances the model by one byte and queues the beats that byte must produce.
   function void decode_byte(input logic [7:0] c);
      logic [7:0] emitted [2];
      int         n;
      int         k;
      bit         line_done;
      n = 0;
      line_done = 1'b0;
      if (!body_end) begin
         if (cr_held) begin
            cr_held = 1'b0;
            if (c == CH_LF) begin
               line_done = 1'b1;
               if (!in_data) begin
                  want_len  = size_acc;
                  size_acc  = '0;
                  size_halt = 1'b0;
                  digit_cnt = 0;
                  got_len   = '0;
                  if (want_len == 0) body_end = 1'b1;
                  else in_data = 1'b1;
               end else begin
                  if (got_len != want_len) sticky_err = 1'b1;
                  in_data = 1'b0;
                  got_len = '0;
               end
            end else if (in_data) begin
               emitted[n] = CH_CR;
               n++;
               if (got_len != '1) got_len++;
            end else begin
               take_size_char(CH_CR);
            end
         end
         if (!line_done) begin
            if (c == CH_CR) begin
               cr_held = 1'b1;
            end else if (in_data) begin
               emitted[n] = c;
               n++;
               if (got_len != '1) got_len++;
            end else begin
               take_size_char(c);
            end
         end
      end
      if (n == 0) due_beats.push_back('{8'h00, 1'b0, body_end, sticky_err, 1'b1});
      for (k = 0; k < n; k++) begin
         due_beats.push_back('{emitted[k], 1'b1, body_end, sticky_err, k == n - 1});
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int         gap;
      logic [7:0] v;
      gap = burst_mode ? 0 : $urandom_range(0, 9);
      v = b;
      // While noise is running, an LF that would close a size line of value zero is bent
      // away so the body stays open.
      if (hold_body && !body_end && !in_data && cr_held && size_acc == 0 && v == CH_LF) begin
         v = 8'h4C;
      end
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      decode_byte(v);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_crlf();
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // Sends a size line for size_val and then len data bytes; len differs from
   // size_val for a broken chunk.
   task automatic send_chunk(input int len, input int size_val);
      logic [7:0] digs[$];
      logic [7:0] d;
      logic [7:0] prev;
      bit         upper;
      int         val;
      int         nib;
      int         pad;
      upper = $urandom_range(0, 1);
      val = size_val;
      do begin
         nib = val % 16;
         if (nib < 10) digs.push_front(8'(8'h30 + nib));
         else digs.push_front(8'((upper ? 8'h41 : 8'h61) + nib - 10));
         val = val / 16;
      end while (val != 0);
      pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_DIGITS - digs.size()) : 0;
      repeat (pad) send_byte(8'h30);
      foreach (digs[i]) send_byte(digs[i]);
      if ($urandom_range(0, 3) == 0) begin
         send_byte(8'h3B);
         repeat ($urandom_range(1, 4)) begin
            d = 8'($urandom_range(0, 255));
            if (d == CH_CR) d = 8'h3D;
            send_byte(d);
         end
      end
      send_crlf();
      prev = 8'h00;
      repeat (len) begin
         d = ($urandom_range(0, 7) == 0) ? CH_CR : 8'($urandom_range(0, 255));
         if (prev == CH_CR && d == CH_LF) d = 8'h2E;
         send_byte(d);
         prev = d;
      end
      send_crlf();
   endtask

   task automatic test_basic_framing();
      send_text("3");
      send_crlf();
      send_text("abc");
      send_crlf();
      // Extension after the size, and data bytes at both ends of the range.
      send_text("4;n=v");
      send_crlf();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_crlf();
      send_text("0002");
      send_crlf();
      send_byte(8'h40);
      send_byte(8'h60);
      send_crlf();
   endtask

   task automatic test_lone_cr();
      send_text("3");
      send_crlf();
      send_text("x");
      send_byte(CH_CR);
      send_text("y");
      send_crlf();
      // Two CRs in a row are both data; the chunk then closes on CR LF.
      send_text("2");
      send_crlf();
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_crlf();
      // A CR inside the size line stops the digits like any other non-hex byte.
      send_text("1");
      send_byte(CH_CR);
      send_text(";");
      send_crlf();
      send_text("z");
      send_crlf();
   endtask

   task automatic test_random_chunks();
      int target;
      int len;
      target = sent_count + 200;
      while (sent_count < target) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         send_chunk(len, len);
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_size_errors();
      send_text("00000001F");
      send_crlf();
      send_text("k");
      send_crlf();
      send_text("FFFFFFFF");
      send_crlf();
      send_text("zz");
      send_crlf();
      send_text("5");
      send_crlf();
      send_text("ab");
      send_crlf();
   endtask

   task automatic test_noise();
      int         target;
      int         len;
      int         delta;
      logic [7:0] d;
      hold_body = 1'b1;
      target = sent_count + 100;
      while (sent_count < target) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         len = $urandom_range(1, 8);
         case ($urandom_range(0, 3))
            0, 1: begin
               delta = $urandom_range(1, 3);
               if ($urandom_range(0, 1)) send_chunk(len + delta, len);
               else send_chunk((len > delta) ? len - delta : 0, len);
            end
            2: send_chunk(len, len);
            default: begin
               repeat ($urandom_range(1, 8)) begin
                  case ($urandom_range(0, 3))
                     0: d = CH_CR;
                     1: d = CH_LF;
                     2: d = 8'(8'h30 + $urandom_range(0, 9));
                     default: d = 8'($urandom_range(0, 255));
                  endcase
                  send_byte(d);
               end
            end
         endcase
      end
      burst_mode = 1'b0;
      hold_body = 1'b0;
   endtask

   task automatic test_body_end();
      // At most three line ends take any state to the end of the body.
      repeat (3) begin
         if (!body_end) send_crlf();
      end
      // Everything after the final chunk is swallowed.
      send_crlf();
      send_text("1");
      repeat (5) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic report_beat(input string what, input beat_type w, input beat_type g);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%s: expected data=%h is_data=%b done=%b err=%b last=%b",
                what, w.data, w.is_data, w.done, w.err, w.last);
         $display(", got data=%h is_data=%b done=%b err=%b last=%b",
                  g.data, g.is_data, g.done, g.err, g.last);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat = '{rsp_tdata[7:0], rsp_tuser[0], rsp_tdata[8], rsp_tdata[9], rsp_tlast};
         if (due_beats.size() == 0) begin
            report_beat("unexpected beat", '0, got_beat);
         end else begin
            want_beat = due_beats.pop_front();
            if (got_beat !== want_beat) report_beat("beat mismatch", want_beat, got_beat);
         end
      end
   end

   initial begin
      @(negedge clock);
      forever begin
         rsp_stall = burst_mode ? 0 : $urandom_range(0, 9);
         if (rsp_stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
         @(negedge clock);
      end
   end

   initial begin
      #2000000;
      $display("http_chunked_body_decoder verification failed");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_framing();
      test_lone_cr();
      test_random_chunks();
      test_size_errors();
      test_noise();
      test_body_end();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("http_chunked_body_decoder verification clean");
      end else begin
         $display("http_chunked_body_decoder verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/hcbd_pkg.sv
rtl/core/hcbd_front.sv
rtl/core/hcbd_fifo.sv
rtl/core/hcbd_back.sv
rtl/core/http_chunked_body_decoder.sv
sim/http_chunked_body_decoder_tb.sv
